// File: sv/b36e_pkg.sv
// ----------------------------------------------------------------------------
// b36e_pkg
// Shared types, constants and the digit alphabet for the base36 encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package b36e_pkg;

  localparam int VALUE_W     = 128;
  localparam int HALF_W      = 64;
  localparam int CHUNK_W     = 16;
  localparam int CHUNKS      = VALUE_W / CHUNK_W;
  localparam int CHUNK_CNT_W = $clog2(CHUNKS);
  localparam int RADIX       = 36;
  localparam int DIGIT_COUNT = 25;
  localparam int DCNT_W      = $clog2(DIGIT_COUNT);
  localparam int DIGIT_W     = 6;
  localparam int CHAR_W      = 7;

  // partial dividend is {remainder, chunk}, always below RADIX << CHUNK_W
  localparam int CUR_W       = DIGIT_W + CHUNK_W;
  // reciprocal of 36, exact for every partial dividend below 2^CUR_W
  localparam int RECIP_SHIFT = CUR_W + DIGIT_W;
  localparam int RECIP_W     = 23;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RECIP_SHIFT) / RADIX + 1);
  localparam int PROD_W      = CUR_W + RECIP_W;

  localparam logic [CHAR_W-1:0] CHAR_ZERO   = 7'd48;  // '0'
  localparam logic [CHAR_W-1:0] CHAR_LETTER = 7'd87;  // 'a' minus ten
  localparam logic [DIGIT_W-1:0] DEC_DIGITS = 6'd10;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT
  } b36e_state_t;

  typedef logic [DIGIT_W-1:0] digit_t;
  typedef logic [CHAR_W-1:0]  char_t;

  // 0-9 then a-z
  function automatic char_t digit_to_char(input digit_t d);
    char_t c;
    if (d < DEC_DIGITS) begin
      c = CHAR_ZERO + CHAR_W'(d);
    end else begin
      c = CHAR_LETTER + CHAR_W'(d);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: sv/b36e_if.sv
// ----------------------------------------------------------------------------
// b36e_if
// Valid/ready channels of the base36 encoder: 128-bit value in, characters out.
// ----------------------------------------------------------------------------
`default_nettype none

interface b36e_in_if import b36e_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [HALF_W-1:0] value_high;
  logic [HALF_W-1:0] value_low;

  modport source (output valid, output value_high, output value_low, input ready);
  modport sink   (input valid, input value_high, input value_low, output ready);
endinterface

interface b36e_out_if import b36e_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] digit_char;
  logic              is_last;

  modport source (output valid, output digit_char, output is_last, input ready);
  modport sink   (input valid, input digit_char, input is_last, output ready);
endinterface

`default_nettype wire

// File: sv/b36e_div_step.sv
// ----------------------------------------------------------------------------
// b36e_div_step
// One long-division step by 36: {remainder, 16-bit chunk} -> quotient chunk
// and new remainder, using a reciprocal multiply and a shift-add correction.
// ----------------------------------------------------------------------------
`default_nettype none

module b36e_div_step import b36e_pkg::*; (
  input  wire logic [DIGIT_W-1:0] rem_in,
  input  wire logic [CHUNK_W-1:0] chunk_in,
  output logic      [CHUNK_W-1:0] quot_out,
  output logic      [DIGIT_W-1:0] rem_out
);

  logic [CUR_W-1:0]  cur;
  logic [PROD_W-1:0] prod;
  logic [CUR_W-1:0]  q_times_radix;

  assign cur  = {rem_in, chunk_in};
  assign prod = PROD_W'(cur) * PROD_W'(RECIP);

  // quotient always fits one chunk since rem_in < 36
  assign quot_out = prod[RECIP_SHIFT +: CHUNK_W];

  // q * 36 = q * 32 + q * 4
  assign q_times_radix = (CUR_W'(quot_out) << 5) + (CUR_W'(quot_out) << 2);
  assign rem_out       = DIGIT_W'(cur - q_times_radix);

endmodule

`default_nettype wire

// File: sv/base36_encoder_128.sv
// ----------------------------------------------------------------------------
// base36_encoder_128
// 128-bit unsigned value to 25 lower-case base36 ASCII characters.
// ----------------------------------------------------------------------------
// Takes one 128-bit word (value_high above value_low) and returns 25 character
// words, most significant digit first, leading zeros kept, is_last on the
// 25th. The value is divided by 36 repeatedly through one shared division
// step that handles 16 bits per cycle, one chunk at a time, for every digit;
// the 25 characters then leave at up to one per cycle as out_ch.ready allows.
// An item occupies the block through its accept, all divide steps and all 25
// character outputs; in_ch.ready is high only while the block is empty. There
// are no configuration registers.
// ----------------------------------------------------------------------------
`default_nettype none

module base36_encoder_128 import b36e_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  b36e_in_if.sink      in_ch,
  b36e_out_if.source   out_ch
);

  b36e_state_t state_r, state_nxt;

  logic [VALUE_W-1:0]     val_r, val_nxt;
  logic [DIGIT_W-1:0]     rem_r, rem_nxt;
  logic [CHUNK_CNT_W-1:0] chunk_cnt_r, chunk_cnt_nxt;
  logic [DCNT_W-1:0]      dig_cnt_r, dig_cnt_nxt;
  digit_t                 dig_r   [DIGIT_COUNT];
  digit_t                 dig_nxt [DIGIT_COUNT];

  logic [CHUNK_W-1:0] step_quot;
  logic [DIGIT_W-1:0] step_rem;

  logic in_fire;
  logic out_fire;
  logic chunk_done;
  logic digit_last;

  b36e_div_step u_div_step (
    .rem_in   (rem_r),
    .chunk_in (val_r[VALUE_W-1 -: CHUNK_W]),
    .quot_out (step_quot),
    .rem_out  (step_rem)
  );

  assign in_fire    = in_ch.valid && in_ch.ready;
  assign out_fire   = out_ch.valid && out_ch.ready;
  assign chunk_done = (chunk_cnt_r == CHUNK_CNT_W'(CHUNKS - 1));
  assign digit_last = (dig_cnt_r == DCNT_W'(DIGIT_COUNT - 1));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (chunk_done && digit_last) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_fire && digit_last) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_ch.ready       = (state_r == ST_IDLE);
    out_ch.valid      = (state_r == ST_EMIT);
    out_ch.digit_char = digit_to_char(dig_r[0]);
    out_ch.is_last    = digit_last;
  end

  // datapath
  always_comb begin
    val_nxt       = val_r;
    rem_nxt       = rem_r;
    chunk_cnt_nxt = chunk_cnt_r;
    dig_cnt_nxt   = dig_cnt_r;
    for (int i = 0; i < DIGIT_COUNT; i++) begin
      dig_nxt[i] = dig_r[i];
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          val_nxt       = {in_ch.value_high, in_ch.value_low};
          rem_nxt       = '0;
          chunk_cnt_nxt = '0;
          dig_cnt_nxt   = '0;
        end
      end
      ST_DIV: begin
        // quotient chunks rotate in at the bottom, full quotient after 8 steps
        val_nxt       = {val_r[VALUE_W-CHUNK_W-1:0], step_quot};
        rem_nxt       = step_rem;
        chunk_cnt_nxt = chunk_cnt_r + CHUNK_CNT_W'(1);
        if (chunk_done) begin
          rem_nxt       = '0;
          chunk_cnt_nxt = '0;
          dig_cnt_nxt   = digit_last ? '0 : dig_cnt_r + DCNT_W'(1);
          // least significant digit comes first, so the top digit ends at slot 0
          dig_nxt[0] = step_rem;
          for (int i = 1; i < DIGIT_COUNT; i++) begin
            dig_nxt[i] = dig_r[i-1];
          end
        end
      end
      ST_EMIT: begin
        if (out_fire) begin
          dig_cnt_nxt = dig_cnt_r + DCNT_W'(1);
          for (int i = 0; i < DIGIT_COUNT - 1; i++) begin
            dig_nxt[i] = dig_r[i+1];
          end
          dig_nxt[DIGIT_COUNT-1] = '0;
        end
      end
      default: begin
        dig_cnt_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      chunk_cnt_r <= '0;
      dig_cnt_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      chunk_cnt_r <= chunk_cnt_nxt;
      dig_cnt_r   <= dig_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
    rem_r <= rem_nxt;
    for (int i = 0; i < DIGIT_COUNT; i++) begin
      dig_r[i] <= dig_nxt[i];
    end
  end

endmodule

`default_nettype wire

// File: sv/b36e_checker.sv
// ----------------------------------------------------------------------------
// b36e_port_checks
// Port-level checks for the base36 encoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module b36e_port_checks import b36e_pkg::*; (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [CHAR_W-1:0] digit_char,
  input wire logic              is_last
);

  // never takes a new value while characters are still going out
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid)
    else $error("input ready while output word pending");

  // a value is busy after it is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready && !out_valid)
    else $error("block not busy after accepting a word");

  // last character ends the burst and frees the input
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && is_last |=> !out_valid && in_ready)
    else $error("output continues after last word");

  // characters are always from the alphabet
  a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (digit_char >= 7'd48 && digit_char <= 7'd57) ||
                  (digit_char >= 7'd97 && digit_char <= 7'd122))
    else $error("character outside base36 alphabet");

  // stalled word holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(digit_char) && $stable(is_last))
    else $error("stalled output word changed");

endmodule

bind base36_encoder_128 b36e_port_checks u_b36e_port_checks (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .digit_char (out_ch.digit_char),
  .is_last    (out_ch.is_last)
);

`default_nettype wire

// File: sim/b36e_checker.sv
// ----------------------------------------------------------------------------
// b36e_checker
// Watches both channels of the base36 encoder and scores every character.
// ----------------------------------------------------------------------------
// Each accepted input word is converted here by repeated division by 36. The
// 25 characters it should produce are queued, and each output word is compared
// with the oldest of them. Mismatches and the number of characters still owed
// are handed to the testbench top.
// ----------------------------------------------------------------------------
`default_nettype none

module b36e_checker import b36e_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_ready,
  input  wire logic [HALF_W-1:0] in_value_high,
  input  wire logic [HALF_W-1:0] in_value_low,
  input  wire logic              out_valid,
  input  wire logic              out_ready,
  input  wire logic [CHAR_W-1:0] out_digit_char,
  input  wire logic              out_is_last,
  output int                     mismatch_count,
  output int                     pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam string B36_ALPHABET = "0123456789abcdefghijklmnopqrstuvwxyz";
  localparam int    SHOWN_MAX    = 10;

  typedef struct packed {
    char_t digit_char;
    logic  is_last;
  } b36_char_t;

  b36_char_t owed_chars[$];
  int        chars_seen;

  // divide by 36 until all digits are out, then queue them msd first
  function automatic void encode_base36(input logic [VALUE_W-1:0] value);
    logic [VALUE_W-1:0] rest;
    b36_char_t          chars[DIGIT_COUNT];
    int                 d;
    int                 k;
    rest = value;
    for (k = DIGIT_COUNT - 1; k >= 0; k--) begin
      d = int'(rest % VALUE_W'(RADIX));
      rest = rest / VALUE_W'(RADIX);
      chars[k].digit_char = char_t'(B36_ALPHABET[d]);
      chars[k].is_last = (k == DIGIT_COUNT - 1);
    end
    for (k = 0; k < DIGIT_COUNT; k++) begin
      owed_chars.push_back(chars[k]);
    end
  endfunction

  initial begin
    mismatch_count = 0;
    pending_count = 0;
    chars_seen = 0;
  end

  always @(posedge clk) begin
    b36_char_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        encode_base36({in_value_high, in_value_low});
      end
      if (out_valid && out_ready) begin
        if (owed_chars.size() == 0) begin
          if (mismatch_count < SHOWN_MAX) begin
            $display("[%0t] unexpected char word %0d: '%c' last=%0b", $realtime,
                     chars_seen, out_digit_char, out_is_last);
          end
          mismatch_count++;
        end else begin
          want = owed_chars.pop_front();
          if (out_digit_char !== want.digit_char || out_is_last !== want.is_last) begin
            if (mismatch_count < SHOWN_MAX) begin
              $display("[%0t] char word %0d: expected '%c' last=%0b, got '%c' (%0d) last=%0b",
                       $realtime, chars_seen, want.digit_char, want.is_last,
                       out_digit_char, out_digit_char, out_is_last);
            end
            mismatch_count++;
          end
        end
        chars_seen++;
      end
      pending_count = owed_chars.size();
    end
  end

endmodule

`default_nettype wire

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the 128-bit base36 encoder.
// ----------------------------------------------------------------------------
// Sends a directed set of values (zero, all ones, half-word edges, powers of
// 36 and their neighbors, bit patterns) and then random values of several
// shapes, in bursts with random gaps. The result side stalls in random
// segments, with one long hold-off that backs the block up. Scoring is done
// by b36e_checker; a watchdog ends the run if the channels go quiet.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import b36e_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  CLK_PERIOD   = 8;
  localparam int  RANDOM_ITEMS = 180;
  localparam int  HOLD_AFTER   = 20;
  localparam int  HOLD_CYCLES  = 700;
  localparam int  TAIL_CYCLES  = 300;
  localparam int  QUIET_LIMIT  = 5000;

  logic clk = 1'b0;
  logic rst_n;
  int   words_sent;
  int   quiet_cycles;
  int   mismatch_count;
  int   pending_count;

  b36e_in_if  in_ch ();
  b36e_out_if out_ch ();

  base36_encoder_128 DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  b36e_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .in_value_high  (in_ch.value_high),
    .in_value_low   (in_ch.value_low),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_digit_char (out_ch.digit_char),
    .out_is_last    (out_ch.is_last),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic logic [VALUE_W-1:0] pow36(input int n);
    logic [VALUE_W-1:0] p;
    p = VALUE_W'(1);
    repeat (n) p = p * VALUE_W'(RADIX);
    return p;
  endfunction

  function automatic logic [VALUE_W-1:0] random_value();
    logic [VALUE_W-1:0] v;
    int                 shape;
    shape = $urandom_range(0, 9);
    v = {$urandom, $urandom, $urandom, $urandom};
    case (shape)
      0: begin
        v = VALUE_W'($urandom);
      end
      1: begin
        v[VALUE_W-1:HALF_W] = '0;
      end
      2: begin
        v[HALF_W-1:0] = ($urandom_range(0, 1) == 1) ? '1 : '0;
      end
      3: begin
        v = '1;
        repeat ($urandom_range(1, 4)) v[$urandom_range(0, VALUE_W - 1)] = 1'b0;
      end
      4: begin
        v = '0;
        repeat ($urandom_range(1, 4)) v[$urandom_range(0, VALUE_W - 1)] = 1'b1;
      end
      5: begin
        v = pow36($urandom_range(1, DIGIT_COUNT - 1)) - VALUE_W'(1)
            + VALUE_W'($urandom_range(0, 2));
      end
      default: begin
      end
    endcase
    return v;
  endfunction

  // valid stays up across back-to-back words in a burst
  task automatic send_value(input logic [VALUE_W-1:0] v);
    @(negedge clk);
    in_ch.valid      <= 1'b1;
    in_ch.value_high <= v[VALUE_W-1:HALF_W];
    in_ch.value_low  <= v[HALF_W-1:0];
    do @(posedge clk); while (!in_ch.ready);
    words_sent++;
  endtask

  task automatic pause(input int n);
    repeat (n) begin
      @(negedge clk);
      in_ch.valid      <= 1'b0;
      in_ch.value_high <= {$urandom, $urandom};
      in_ch.value_low  <= {$urandom, $urandom};
    end
  endtask

  initial begin : stimulus
    logic [VALUE_W-1:0] values[$];
    int                 burst_left;
    int                 gap;
    int                 i;
    rst_n            = 1'b0;
    words_sent       = 0;
    in_ch.valid      = 1'b0;
    in_ch.value_high = '0;
    in_ch.value_low  = '0;

    values.push_back('0);
    values.push_back('1);
    values.push_back({{HALF_W{1'b1}}, {HALF_W{1'b0}}});
    values.push_back({{HALF_W{1'b0}}, {HALF_W{1'b1}}});
    values.push_back(VALUE_W'(1));
    values.push_back(VALUE_W'(35));
    values.push_back(VALUE_W'(36));
    values.push_back(VALUE_W'(1) << HALF_W);
    values.push_back(VALUE_W'(1) << (VALUE_W - 1));
    values.push_back({(VALUE_W / 4){4'ha}});
    values.push_back({(VALUE_W / 4){4'h5}});
    values.push_back(pow36(12));
    values.push_back(pow36(12) - VALUE_W'(1));
    values.push_back(pow36(DIGIT_COUNT - 1));
    values.push_back(pow36(DIGIT_COUNT - 1) - VALUE_W'(1));
    values.push_back('1 - VALUE_W'(1));
    values.push_back(128'h0123456789abcdef_fedcba9876543210);
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      values.push_back(random_value());
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    burst_left = $urandom_range(1, 8);
    foreach (values[i]) begin
      send_value(values[i]);
      burst_left--;
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300) : $urandom_range(0, 30);
        pause(gap);
        burst_left = $urandom_range(1, 8);
      end
    end
    @(negedge clk);
    in_ch.valid <= 1'b0;

    while (pending_count != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  // result side: random stall segments, one long hold-off once traffic is going
  initial begin : result_stalls
    int  mode;
    int  seg_len;
    int  k;
    bit  held;
    held = 1'b0;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (!held && words_sent >= HOLD_AFTER) begin
        held = 1'b1;
        for (k = 0; k < HOLD_CYCLES; k++) begin
          @(negedge clk);
          out_ch.ready <= 1'b0;
        end
      end
      mode = $urandom_range(0, 3);
      seg_len = $urandom_range(20, 400);
      for (k = 0; k < seg_len; k++) begin
        @(negedge clk);
        case (mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= ($urandom_range(0, 3) != 0);
          2: out_ch.ready <= ((k % 5) != 2);
          default: out_ch.ready <= ($urandom_range(0, 1) == 1);
        endcase
      end
    end
  end

  // counts cycles with no word moving on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

`default_nettype wire

// File: base36_encoder_128.f
sv/b36e_pkg.sv
sv/b36e_if.sv
sv/b36e_div_step.sv
sv/base36_encoder_128.sv
sv/b36e_checker.sv
sim/b36e_checker.sv
sim/tb_top.sv
